[src/sks_pkg.sv]
// Shared constants, types and table builder for the ship kinematics step block.
// No dependencies; every other file imports this package.
package sks_pkg;

  // Table and position sizing
  localparam int SINE_ENTRIES = 256;
  localparam int POS_WIDTH    = 32;
  localparam int IDX_W        = $clog2(SINE_ENTRIES + 1);

  // Field widths
  localparam int RATE_W    = 16;
  localparam int TICK_W    = 16;
  localparam int SPEED_W   = 16;
  localparam int HEAD_W    = 13;
  localparam int VEL_W     = 16;
  localparam int TRIG_W    = 16;
  localparam int OUT_POS_W = 32;

  // Angles in 1/16 degree
  localparam int QUARTER_TURN = 1440;
  localparam int HALF_TURN    = 2880;
  localparam int FULL_TURN    = 5760;

  // Heading wrap: bias the raw heading positive, then strip multiples of a turn
  localparam int HACC_W     = 18;
  localparam int WRAP_STEPS = 5;
  localparam int WRAP_OFS   = FULL_TURN * 12;

  // Shared multiplier
  localparam int MUL_W       = 25;
  localparam int RECIP_SHIFT = 32;
  localparam longint unsigned IDX_RECIP =
    ((64'd1 << RECIP_SHIFT) + QUARTER_TURN - 1) / QUARTER_TURN;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACCEL_RATE = 4'd0,
    REG_TURN_RATE  = 4'd1,
    REG_MIN_SPEED  = 4'd2,
    REG_MAX_SPEED  = 4'd3
  } cfg_reg_t;

  typedef logic signed [MUL_W-1:0]   mul_op_t;
  typedef logic signed [2*MUL_W-1:0] mul_prod_t;
  typedef logic [TRIG_W-1:0]         sine_tab_t [SINE_ENTRIES+1];

  // Q15 quarter-wave sample from a truncating Q30 odd series through x^9.
  function automatic logic [TRIG_W-1:0] quarter_sine(int unsigned idx);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sum;
    x    = (64'(idx) * HALF_PI_Q30) / SINE_ENTRIES;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >> 30) / 6;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 20;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 42;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 72;
    sum  = sum + term;
    sum  = (sum + 64'd16384) >> 15;
    if (sum > 64'd32768) begin
      sum = 64'd32768;
    end
    return sum[TRIG_W-1:0];
  endfunction

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t tab;
    for (int i = 0; i <= SINE_ENTRIES; i++) begin
      tab[i] = quarter_sine(i);
    end
    return tab;
  endfunction

endpackage

[src/sks_mul.sv]
// Shared signed multiplier with a registered product.
// Depends on sks_pkg for operand and product types.
module sks_mul (
  input  logic               clk,
  input  sks_pkg::mul_op_t   op_a,
  input  sks_pkg::mul_op_t   op_b,
  output sks_pkg::mul_prod_t prod_r
);
  import sks_pkg::*;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

[src/sks_sine_rom.sv]
// Quarter-wave sine table, Q15, with a registered read port.
// Depends on sks_pkg for the table builder and sizes.
module sks_sine_rom (
  input  logic                       clk,
  input  logic [sks_pkg::IDX_W-1:0]  addr,
  output logic [sks_pkg::TRIG_W-1:0] data_r
);
  import sks_pkg::*;

  localparam sine_tab_t SINE_TAB = build_sine_tab();

  always_ff @(posedge clk) begin
    data_r <= SINE_TAB[addr];
  end

endmodule

[src/ship_kinematics_step_top.sv]
// Ship kinematics step: speed ramp, heading turn, velocity and position per tick.
// Depends on sks_pkg, sks_mul and sks_sine_rom.
//
//  Channel | Direction | Handshake         | Beat contents
//  --------+-----------+-------------------+-------------------------------------------
//  in_     | in        | in_valid/in_stall | tick_len, target_speed, target_heading
//  out_    | out       | out_valid/out_stall | cur_speed, cur_heading, vel_x/z, pos_x/z
//  cfg_    | in        | cfg_valid/cfg_ready | cfg_index, cfg_data (register write)
//
// A tick runs from the idle state through eleven sequencer steps before the next input
// beat can be taken, set by the single shared 25x25 multiplier that runs the six
// products and the two table-index reciprocal multiplies one after another.
// rst_n is synchronous: it restores the register defaults and clears speed,
// heading and position. The result waits in an output register; out_stall only
// holds the last step, and in_stall is high from acceptance until it is loaded.
module ship_kinematics_step_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic        [sks_pkg::TICK_W-1:0]     in_tick_len,
  input  logic signed [sks_pkg::SPEED_W-1:0]    in_target_speed,
  input  logic        [sks_pkg::HEAD_W-1:0]     in_target_heading,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [sks_pkg::SPEED_W-1:0]    out_cur_speed,
  output logic        [sks_pkg::HEAD_W-1:0]     out_cur_heading,
  output logic signed [sks_pkg::VEL_W-1:0]      out_vel_x,
  output logic signed [sks_pkg::VEL_W-1:0]      out_vel_z,
  output logic signed [sks_pkg::OUT_POS_W-1:0]  out_pos_x,
  output logic signed [sks_pkg::OUT_POS_W-1:0]  out_pos_z,
  // configuration write channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic        [sks_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [sks_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sks_pkg::*;

  localparam int N_W       = $clog2((QUARTER_TURN - 1) * SINE_ENTRIES + QUARTER_TURN / 2 + 1);
  localparam int POS_EXT_W = (POS_WIDTH > OUT_POS_W) ? POS_WIDTH : OUT_POS_W;

  // Sequencer: one step of the shared multiplier per state
  typedef enum logic [11:0] {
    ST_IDLE = 12'h001,  // wait for an input beat
    ST_DS   = 12'h002,  // multiply accel * dt
    ST_DH   = 12'h004,  // multiply turn * dt, update speed
    ST_HEAD = 12'h008,  // step heading toward target
    ST_WRAP = 12'h010,  // wrap heading into one turn
    ST_IDXZ = 12'h020,  // table index for sine
    ST_IDXX = 12'h040,  // table index for cosine, read sine
    ST_VZ   = 12'h080,  // |sine| * |speed|, read cosine
    ST_VX   = 12'h100,  // |cosine| * |speed|, form vel_z
    ST_PZ   = 12'h200,  // vel_z * dt, form vel_x
    ST_PX   = 12'h400,  // vel_x * dt, advance pos_z
    ST_FIN  = 12'h800   // advance pos_x, load result
  } state_t;

  typedef struct packed {
    logic [1:0]     quad;
    logic [N_W-1:0] n;
  } angle_split_t;

  state_t state_r, state_nxt;

  // Configuration registers
  logic        [RATE_W-1:0]  accel_r, turn_r;
  logic signed [SPEED_W-1:0] min_r, max_r;

  // Kinematic state
  logic signed [SPEED_W-1:0]   speed_r;
  logic        [HEAD_W-1:0]    head_r;
  logic        [POS_WIDTH-1:0] pos_x_r, pos_z_r;

  // Latched input beat and working values
  logic        [TICK_W-1:0]  tick_r;
  logic signed [SPEED_W-1:0] want_speed_r;
  logic        [HEAD_W-1:0]  want_head_r;
  logic        [HACC_W-1:0]  hacc_r;
  logic signed [VEL_W-1:0]   vel_x_r, vel_z_r;

  // Result register
  logic                        out_valid_r;
  logic signed [SPEED_W-1:0]   out_speed_r;
  logic        [HEAD_W-1:0]    out_head_r;
  logic signed [VEL_W-1:0]     out_vel_x_r, out_vel_z_r;
  logic        [OUT_POS_W-1:0] out_pos_x_r, out_pos_z_r;

  // Shared units
  mul_op_t               mul_a, mul_b;
  mul_prod_t             prod_r;
  logic [IDX_W-1:0]      rom_addr;
  logic [TRIG_W-1:0]     rom_q;

  logic                  in_accept, out_load, cfg_accept;
  logic [HEAD_W-1:0]     want_head_in;
  logic [HEAD_W-1:0]     head_cos;
  angle_split_t          split_z, split_x;
  logic signed [16:0]    spd_wide;
  logic        [16:0]    spd_mag;
  logic signed [SPEED_W-1:0] speed_nxt;
  logic        [HACC_W-1:0]  hacc_nxt;
  logic        [HEAD_W-1:0]  head_nxt;
  logic        [POS_WIDTH-1:0] pos_step, pos_x_nxt;
  logic        [POS_EXT_W-1:0] pos_x_ext, pos_z_ext;

  // ---------------------------------------------------------------------------
  // Helpers
  // ---------------------------------------------------------------------------
  // Split a heading into quadrant and the numerator of the rounded table index.
  function automatic angle_split_t split_angle(logic [HEAD_W-1:0] h);
    angle_split_t s;
    logic [HEAD_W-1:0] r;
    if (h >= HEAD_W'(3 * QUARTER_TURN)) begin
      s.quad = 2'd3;
    end else if (h >= HEAD_W'(HALF_TURN)) begin
      s.quad = 2'd2;
    end else if (h >= HEAD_W'(QUARTER_TURN)) begin
      s.quad = 2'd1;
    end else begin
      s.quad = 2'd0;
    end
    r   = h - HEAD_W'(32'(s.quad) * QUARTER_TURN);
    s.n = N_W'(r) * N_W'(SINE_ENTRIES) + N_W'(QUARTER_TURN / 2);
    return s;
  endfunction

  // Clamp and mirror the reciprocal quotient into a table address.
  function automatic logic [IDX_W-1:0] table_addr(mul_prod_t p, logic [1:0] quad);
    logic [IDX_W-1:0] idx;
    idx = p[RECIP_SHIFT +: IDX_W];
    if (idx > IDX_W'(SINE_ENTRIES)) begin
      idx = IDX_W'(SINE_ENTRIES);
    end
    if (quad[0]) begin
      idx = IDX_W'(SINE_ENTRIES) - idx;
    end
    return idx;
  endfunction

  // Round the Q15 product, saturate and apply the sign.
  function automatic logic signed [VEL_W-1:0] scale_vel(mul_prod_t p, logic neg);
    logic [31:0] rsum;
    logic [16:0] m;
    rsum = p[31:0] + 32'd16384;
    m    = rsum[31:15];
    if (neg) begin
      if (m > 17'd32768) begin
        m = 17'd32768;
      end
      m = -m;
    end else if (m > 17'd32767) begin
      m = 17'd32767;
    end
    return m[VEL_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Handshakes
  // ---------------------------------------------------------------------------
  assign in_stall   = (state_r != ST_IDLE) || !rst_n;
  assign in_accept  = in_valid && !in_stall;
  assign out_load   = (state_r == ST_FIN) && (!out_valid_r || !out_stall);
  assign cfg_ready  = rst_n;
  assign cfg_accept = cfg_valid && cfg_ready;

  // Drop out-of-range targets by one turn.
  assign want_head_in = (in_target_heading >= HEAD_W'(FULL_TURN)) ?
                        in_target_heading - HEAD_W'(FULL_TURN) : in_target_heading;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_accept) state_nxt = ST_DS;
      ST_DS:   state_nxt = ST_DH;
      ST_DH:   state_nxt = ST_HEAD;
      ST_HEAD: state_nxt = ST_WRAP;
      ST_WRAP: state_nxt = ST_IDXZ;
      ST_IDXZ: state_nxt = ST_IDXX;
      ST_IDXX: state_nxt = ST_VZ;
      ST_VZ:   state_nxt = ST_VX;
      ST_VX:   state_nxt = ST_PZ;
      ST_PZ:   state_nxt = ST_PX;
      ST_PX:   state_nxt = ST_FIN;
      ST_FIN:  if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared multiplier operand select
  // ---------------------------------------------------------------------------
  // Cosine uses the heading advanced by a quarter turn.
  assign head_cos = (head_r >= HEAD_W'(FULL_TURN - QUARTER_TURN)) ?
                    head_r - HEAD_W'(FULL_TURN - QUARTER_TURN) :
                    head_r + HEAD_W'(QUARTER_TURN);
  assign split_z  = split_angle(head_r);
  assign split_x  = split_angle(head_cos);

  assign spd_wide = 17'(speed_r);
  assign spd_mag  = spd_wide[16] ? 17'(-spd_wide) : 17'(spd_wide);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_DS: begin
        mul_a = mul_op_t'(accel_r);
        mul_b = mul_op_t'(tick_r);
      end
      ST_DH: begin
        mul_a = mul_op_t'(turn_r);
        mul_b = mul_op_t'(tick_r);
      end
      ST_IDXZ: begin
        mul_a = mul_op_t'(split_z.n);
        mul_b = mul_op_t'(IDX_RECIP);
      end
      ST_IDXX: begin
        mul_a = mul_op_t'(split_x.n);
        mul_b = mul_op_t'(IDX_RECIP);
      end
      ST_VZ, ST_VX: begin
        mul_a = mul_op_t'(rom_q);
        mul_b = mul_op_t'(spd_mag);
      end
      ST_PZ: begin
        mul_a = mul_op_t'(vel_z_r);
        mul_b = mul_op_t'(tick_r);
      end
      ST_PX, ST_FIN: begin
        // FIN keeps the operands so the product holds while the result waits
        mul_a = mul_op_t'(vel_x_r);
        mul_b = mul_op_t'(tick_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  sks_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod_r)
  );

  // Sine address comes out of IDXX, cosine address out of VZ.
  assign rom_addr = (state_r == ST_IDXX) ? table_addr(prod_r, split_z.quad)
                                         : table_addr(prod_r, split_x.quad);

  sks_sine_rom u_sine_rom (
    .clk    (clk),
    .addr   (rom_addr),
    .data_r (rom_q)
  );

  // ---------------------------------------------------------------------------
  // Speed: ramp toward target by accel*dt, raise to min, then lower to max
  // ---------------------------------------------------------------------------
  always_comb begin
    logic signed [17:0] cur, step, sum;
    cur  = 18'(speed_r);
    step = 18'(prod_r[31:16]);
    if (want_speed_r > speed_r) begin
      sum = cur + step;
    end else if (want_speed_r < speed_r) begin
      sum = cur - step;
    end else begin
      sum = cur;
    end
    if (sum < 18'(min_r)) begin
      sum = 18'(min_r);
    end
    if (sum > 18'(max_r)) begin
      sum = 18'(max_r);
    end
    speed_nxt = sum[SPEED_W-1:0];
  end

  // ---------------------------------------------------------------------------
  // Heading: turn the short way by turn*dt, bias positive for the wrap step
  // ---------------------------------------------------------------------------
  always_comb begin
    logic signed [HACC_W-1:0] h, w, dh, diff, v;
    h    = HACC_W'(head_r);
    w    = HACC_W'(want_head_r);
    dh   = HACC_W'(prod_r[31:16]);
    diff = w - h;
    if (w > h) begin
      v = (diff > HACC_W'(HALF_TURN)) ? h - dh : h + dh;
    end else if (w < h) begin
      v = (diff < -HACC_W'(HALF_TURN)) ? h + dh : h - dh;
    end else begin
      v = h;
    end
    hacc_nxt = HACC_W'(v + HACC_W'(WRAP_OFS));
  end

  // Strip turns by binary-weighted compare and subtract.
  always_comb begin
    logic [HACC_W-1:0] a;
    a = hacc_r;
    for (int k = WRAP_STEPS - 1; k >= 0; k--) begin
      if (a >= (HACC_W'(FULL_TURN) << k)) begin
        a = a - (HACC_W'(FULL_TURN) << k);
      end
    end
    head_nxt = a[HEAD_W-1:0];
  end

  // ---------------------------------------------------------------------------
  // Position step = floor(vel * dt / 65536), sign-extended into the register
  // ---------------------------------------------------------------------------
  assign pos_step  = POS_WIDTH'(signed'(prod_r[31:16]));
  assign pos_x_nxt = pos_x_r + pos_step;
  assign pos_x_ext = POS_EXT_W'(pos_x_nxt);
  assign pos_z_ext = POS_EXT_W'(pos_z_r);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_r <= RATE_W'(256);
      turn_r  <= RATE_W'(480);
      min_r   <= '0;
      max_r   <= SPEED_W'(2560);
    end else if (cfg_accept) begin
      unique case (cfg_index)
        REG_ACCEL_RATE: accel_r <= cfg_data;
        REG_TURN_RATE:  turn_r  <= cfg_data;
        REG_MIN_SPEED:  min_r   <= cfg_data;
        REG_MAX_SPEED:  max_r   <= cfg_data;
        default: ;  // ignore unknown indexes
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Kinematic state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r <= '0;
      head_r  <= '0;
      pos_x_r <= '0;
      pos_z_r <= '0;
    end else begin
      if (state_r == ST_DH) begin
        speed_r <= speed_nxt;
      end
      if (state_r == ST_WRAP) begin
        head_r <= head_nxt;
      end
      if (state_r == ST_PX) begin
        pos_z_r <= pos_z_r + pos_step;
      end
      if (out_load) begin
        pos_x_r <= pos_x_nxt;
      end
    end
  end

  // Working registers: latch the beat, hold intermediates
  always_ff @(posedge clk) begin
    if (in_accept) begin
      tick_r       <= in_tick_len;
      want_speed_r <= in_target_speed;
      want_head_r  <= want_head_in;
    end
    if (state_r == ST_HEAD) begin
      hacc_r <= hacc_nxt;
    end
    if (state_r == ST_VX) begin
      vel_z_r <= scale_vel(prod_r, split_z.quad[1] ^ speed_r[SPEED_W-1]);
    end
    if (state_r == ST_PZ) begin
      vel_x_r <= scale_vel(prod_r, split_x.quad[1] ^ speed_r[SPEED_W-1]);
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: load when empty or being taken, hold while stalled
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_speed_r <= speed_r;
      out_head_r  <= head_r;
      out_vel_x_r <= vel_x_r;
      out_vel_z_r <= vel_z_r;
      out_pos_x_r <= pos_x_ext[OUT_POS_W-1:0];
      out_pos_z_r <= pos_z_ext[OUT_POS_W-1:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_cur_speed   = out_speed_r;
  assign out_cur_heading = out_head_r;
  assign out_vel_x       = out_vel_x_r;
  assign out_vel_z       = out_vel_z_r;
  assign out_pos_x       = signed'(out_pos_x_r);
  assign out_pos_z       = signed'(out_pos_z_r);

endmodule

[src/sks_checker.sv]
// Port-level checks for the ship kinematics step block, bound to its top level.
// Depends on sks_pkg and ship_kinematics_step_top.
module sks_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_valid,
  input logic                                  in_stall,
  input logic        [sks_pkg::TICK_W-1:0]     in_tick_len,
  input logic signed [sks_pkg::SPEED_W-1:0]    in_target_speed,
  input logic        [sks_pkg::HEAD_W-1:0]     in_target_heading,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic signed [sks_pkg::SPEED_W-1:0]    out_cur_speed,
  input logic        [sks_pkg::HEAD_W-1:0]     out_cur_heading,
  input logic signed [sks_pkg::VEL_W-1:0]      out_vel_x,
  input logic signed [sks_pkg::VEL_W-1:0]      out_vel_z,
  input logic signed [sks_pkg::OUT_POS_W-1:0]  out_pos_x,
  input logic signed [sks_pkg::OUT_POS_W-1:0]  out_pos_z
);
  import sks_pkg::*;

  // Busy right after taking a beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while previous tick still in work");

  // A fresh result leaves the block ready for the next tick
  a_ready_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_stall)
    else $error("result shown but input side still busy");

  // Heading on a result beat always lies within one turn
  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_cur_heading < HEAD_W'(FULL_TURN))
    else $error("heading out of range");

  // Stalled input beat holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_tick_len)
      && $stable(in_target_speed) && $stable(in_target_heading))
    else $error("stalled input beat changed");

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pos_x) && $stable(out_pos_z)
      && $stable(out_cur_speed) && $stable(out_cur_heading)
      && $stable(out_vel_x) && $stable(out_vel_z))
    else $error("stalled result beat changed");

endmodule

bind ship_kinematics_step_top sks_checker u_sks_checker (.*);

[tb/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for ship_kinematics_step_top: steers speed and heading per tick, checks
// velocity and position. Depends on sks_pkg and the RTL under src/; nothing else is read.
module testbench;
  import sks_pkg::*;

  // Run shape
  localparam int RESET_CYCLES     = 7;
  localparam int RANDOM_PER_PHASE = 160;
  localparam int SETTLE_CYCLES    = 24;
  localparam int CYCLE_LIMIT      = 400000;  // far above a fully stalled run
  localparam int PRINT_CAP        = 40;

  // Register defaults after reset
  localparam int ACCEL_DEFAULT = 256;
  localparam int TURN_DEFAULT  = 480;
  localparam int MIN_DEFAULT   = 0;
  localparam int MAX_DEFAULT   = 2560;

  // Indexes that decode to no register
  localparam logic [CFG_IDX_W-1:0] UNUSED_REG_LO = CFG_IDX_W'(REG_MAX_SPEED + 1);
  localparam logic [CFG_IDX_W-1:0] UNUSED_REG_HI = '1;

  // Pacing per random phase: none, sender gaps, receiver stalls, both
  localparam int IDLE_PCT  [4] = '{0, 72, 0, 26};
  localparam int STALL_PCT [4] = '{0, 0, 72, 26};

  typedef struct {
    logic        [TICK_W-1:0]  tick_len;
    logic signed [SPEED_W-1:0] target_speed;
    logic        [HEAD_W-1:0]  target_heading;
    bit                        drain_first;   // hold this beat until every result is back
  } tick_cmd_t;

  typedef struct {
    logic signed [SPEED_W-1:0]   speed;
    logic        [HEAD_W-1:0]    heading;
    logic signed [VEL_W-1:0]     vel_x;
    logic signed [VEL_W-1:0]     vel_z;
    logic signed [OUT_POS_W-1:0] pos_x;
    logic signed [OUT_POS_W-1:0] pos_z;
  } motion_t;

  // DUT ports; every input starts at a known value
  logic                     clk;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic        [TICK_W-1:0]  in_tick_len = '0;
  logic signed [SPEED_W-1:0] in_target_speed = '0;
  logic        [HEAD_W-1:0]  in_target_heading = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [SPEED_W-1:0]   out_cur_speed;
  logic        [HEAD_W-1:0]    out_cur_heading;
  logic signed [VEL_W-1:0]     out_vel_x;
  logic signed [VEL_W-1:0]     out_vel_z;
  logic signed [OUT_POS_W-1:0] out_pos_x;
  logic signed [OUT_POS_W-1:0] out_pos_z;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [CFG_DATA_W-1:0]       cfg_data = '0;

  // Tick queues: beats waiting to be driven, motion results waiting to come back
  tick_cmd_t ticks_pending[$];
  motion_t   motion_expected[$];

  // Predicted register file and vehicle state
  int accel_cfg = ACCEL_DEFAULT;
  int turn_cfg  = TURN_DEFAULT;
  int min_cfg   = MIN_DEFAULT;
  int max_cfg   = MAX_DEFAULT;
  int speed_now = 0;
  int heading_now = 0;
  logic [POS_WIDTH-1:0] pos_x_now = '0;
  logic [POS_WIDTH-1:0] pos_z_now = '0;
  int sine_q15 [0:SINE_ENTRIES];

  // Pacing knobs, changed only while the block is drained
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;

  int error_count    = 0;
  int ticks_accepted = 0;
  int results_seen   = 0;
  int reg_writes     = 0;
  int cycle_count    = 0;

  ship_kinematics_step_top u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_tick_len       (in_tick_len),
    .in_target_speed   (in_target_speed),
    .in_target_heading (in_target_heading),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_cur_speed     (out_cur_speed),
    .out_cur_heading   (out_cur_heading),
    .out_vel_x         (out_vel_x),
    .out_vel_z         (out_vel_z),
    .out_pos_x         (out_pos_x),
    .out_pos_z         (out_pos_z),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic log_error(string msg);
    error_count++;
    if (error_count <= PRINT_CAP) begin
      $display("ERROR @%0t: %s", $time, msg);
    end
  endtask

  // Q15 quarter-wave sample: truncating Q30 odd series up to x^9, rounded to Q15.
  function automatic int q15_sample(int unsigned idx);
    longint unsigned ang;
    longint unsigned ang_sq;
    longint unsigned term;
    longint unsigned acc;
    ang    = (64'(idx) * HALF_PI_Q30) / 64'(SINE_ENTRIES);
    ang_sq = (ang * ang) >> 30;
    term   = ang;
    acc    = ang;
    for (int k = 1; k <= 4; k++) begin
      term = ((term * ang_sq) >> 30) / 64'((2 * k) * (2 * k + 1));
      acc  = (k % 2 == 1) ? acc - term : acc + term;
    end
    acc = (acc + 64'd16384) >> 15;
    if (acc > 64'd32768) begin
      acc = 64'd32768;
    end
    return int'(acc);
  endfunction

  // Signed Q15 sine of a heading in 1/16 degree, through the quarter-wave table.
  function automatic int trig_q15(int h);
    int quad;
    int rem;
    int idx;
    int v;
    quad = (h / QUARTER_TURN) % 4;
    rem  = h % QUARTER_TURN;
    idx  = (rem * SINE_ENTRIES + QUARTER_TURN / 2) / QUARTER_TURN;
    if (idx > SINE_ENTRIES) begin
      idx = SINE_ENTRIES;
    end
    if (quad % 2 == 1) begin
      idx = SINE_ENTRIES - idx;
    end
    v = sine_q15[idx];
    return (quad >= 2) ? -v : v;
  endfunction

  // Speed times a Q15 ratio, rounded half up on magnitude, saturated to 16 bits.
  function automatic int scale_by_trig(int trig, int spd);
    bit     neg;
    longint mag;
    neg = (trig < 0) != (spd < 0);
    mag = (longint'(trig < 0 ? -trig : trig) * longint'(spd < 0 ? -spd : spd) + 16384) >>> 15;
    if (neg) begin
      if (mag > 32768) begin
        mag = 32768;
      end
      return -int'(mag);
    end
    if (mag > 32767) begin
      mag = 32767;
    end
    return int'(mag);
  endfunction

  // Advance the vehicle by one accepted tick and queue the motion it must report.
  function automatic void predict_motion(logic [TICK_W-1:0] dt_raw,
                                         logic signed [SPEED_W-1:0] want_spd_raw,
                                         logic [HEAD_W-1:0] want_head_raw);
    int      dt;
    int      want_spd;
    int      want_head;
    int      ds;
    int      dh;
    int      spd;
    int      h;
    int      vx;
    int      vz;
    motion_t m;
    dt        = dt_raw;
    want_spd  = want_spd_raw;
    want_head = want_head_raw;
    // Fold an out-of-range target back into one turn
    if (want_head >= FULL_TURN) begin
      want_head -= FULL_TURN;
    end
    ds  = int'((longint'(accel_cfg) * dt) >>> 16);
    dh  = int'((longint'(turn_cfg) * dt) >>> 16);
    spd = speed_now;
    h   = heading_now;

    // Ramp speed, then raise to min and lower to max: max wins if they cross
    if (want_spd > spd) begin
      spd += ds;
    end else if (want_spd < spd) begin
      spd -= ds;
    end
    if (spd < min_cfg) begin
      spd = min_cfg;
    end
    if (spd > max_cfg) begin
      spd = max_cfg;
    end

    // Turn toward the target, the short way when the gap exceeds a half turn
    if (want_head > h) begin
      h = (want_head - h > HALF_TURN) ? h - dh : h + dh;
    end else if (want_head < h) begin
      h = (want_head - h < -HALF_TURN) ? h + dh : h - dh;
    end
    h %= FULL_TURN;
    if (h < 0) begin
      h += FULL_TURN;
    end

    speed_now   = spd;
    heading_now = h;
    vx = scale_by_trig(trig_q15((h + QUARTER_TURN) % FULL_TURN), spd);
    vz = scale_by_trig(trig_q15(h), spd);
    pos_x_now = pos_x_now + POS_WIDTH'((longint'(vx) * dt) >>> 16);
    pos_z_now = pos_z_now + POS_WIDTH'((longint'(vz) * dt) >>> 16);

    m.speed   = SPEED_W'(spd);
    m.heading = HEAD_W'(h);
    m.vel_x   = VEL_W'(vx);
    m.vel_z   = VEL_W'(vz);
    m.pos_x   = OUT_POS_W'(pos_x_now);
    m.pos_z   = OUT_POS_W'(pos_z_now);
    motion_expected.push_back(m);
  endfunction

  function automatic void push_tick(int dt, int spd, int head, bit hold);
    tick_cmd_t c;
    c.tick_len       = TICK_W'(dt);
    c.target_speed   = SPEED_W'(spd);
    c.target_heading = HEAD_W'(head);
    c.drain_first    = hold;
    ticks_pending.push_back(c);
  endfunction

  // One register write beat; update the predicted register file where it lands.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    case (idx)
      REG_ACCEL_RATE: accel_cfg = val;
      REG_TURN_RATE:  turn_cfg = val;
      REG_MIN_SPEED:  min_cfg = $signed(val);
      REG_MAX_SPEED:  max_cfg = $signed(val);
      default: ;  // unmapped index: the block drops it
    endcase
    reg_writes++;
    cfg_valid <= 1'b0;
  endtask

  // Hold until every queued tick is driven and every motion result is back.
  task automatic drain_all();
    while (ticks_pending.size() != 0 || motion_expected.size() != 0 || in_valid) begin
      @(posedge clk);
    end
  endtask

  // Driver: close the handshake on the current beat, then maybe launch the next one.
  // Decide valid once per edge so it never sees two updates in one step.
  always @(posedge clk) begin : feed
    tick_cmd_t nxt;
    logic      valid_next;
    valid_next = in_valid;
    if (in_valid && !in_stall) begin
      predict_motion(in_tick_len, in_target_speed, in_target_heading);
      ticks_accepted++;
      valid_next = 1'b0;
    end
    // Launch only from an empty slot; a stalled beat stays put
    if (rst_n && !valid_next && ticks_pending.size() != 0) begin
      if ((!ticks_pending[0].drain_first || motion_expected.size() == 0) &&
          $urandom_range(99) >= sender_idle_pct) begin
        nxt = ticks_pending.pop_front();
        in_tick_len       <= nxt.tick_len;
        in_target_speed   <= nxt.target_speed;
        in_target_heading <= nxt.target_heading;
        valid_next = 1'b1;
      end
    end
    in_valid <= valid_next;
  end

  // Monitor: check each accepted result beat against the oldest prediction.
  always @(posedge clk) begin : watch
    motion_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (motion_expected.size() == 0) begin
        log_error($sformatf("result beat %0d arrived with no tick outstanding", results_seen));
      end else begin
        want = motion_expected.pop_front();
        if (out_cur_speed !== want.speed)
          log_error($sformatf("beat %0d speed: expected %0d got %0d",
                              results_seen, want.speed, out_cur_speed));
        if (out_cur_heading !== want.heading)
          log_error($sformatf("beat %0d heading: expected %0d got %0d",
                              results_seen, want.heading, out_cur_heading));
        if (out_vel_x !== want.vel_x)
          log_error($sformatf("beat %0d vel_x: expected %0d got %0d",
                              results_seen, want.vel_x, out_vel_x));
        if (out_vel_z !== want.vel_z)
          log_error($sformatf("beat %0d vel_z: expected %0d got %0d",
                              results_seen, want.vel_z, out_vel_z));
        if (out_pos_x !== want.pos_x)
          log_error($sformatf("beat %0d pos_x: expected %0d got %0d",
                              results_seen, want.pos_x, out_pos_x));
        if (out_pos_z !== want.pos_z)
          log_error($sformatf("beat %0d pos_z: expected %0d got %0d",
                              results_seen, want.pos_z, out_pos_z));
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog: abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("ship_kinematics_step_top verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    int dt;
    int spd;
    int head;
    for (int i = 0; i <= SINE_ENTRIES; i++) begin
      sine_q15[i] = q15_sample(i);
    end
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Defaults in force: the floor at zero holds a reverse request, then a small ramp up
    push_tick(16'hFFFF, -32768, 0, 1'b0);
    push_tick(16'hFFFF, 32767, 0, 1'b0);
    drain_all();

    // Widest limits and fastest rates; with turn rate at full scale the turn step is dt-1
    write_reg(REG_ACCEL_RATE, 16'hFFFF);
    write_reg(REG_TURN_RATE, 16'hFFFF);
    write_reg(REG_MIN_SPEED, 16'h8000);
    write_reg(REG_MAX_SPEED, 16'h7FFF);
    push_tick(1441, -32768, QUARTER_TURN, 1'b0);       // land on 90 deg
    push_tick(16'hFFFF, -32768, QUARTER_TURN, 1'b0);   // speed pinned at the floor
    // Gap of exactly half a turn turns the long way: lands on 270 deg, where
    // full reverse speed times a negative unit sine saturates to the positive max
    push_tick(2881, -32768, 3 * QUARTER_TURN, 1'b0);
    push_tick(2882, -32768, QUARTER_TURN - 1, 1'b0);   // short way across zero
    push_tick(16'hFFFF, 32767, 8191, 1'b0);            // out-of-range target, huge turn step
    push_tick(16'hFFFF, 32767, 0, 1'b0);
    push_tick(0, 0, 0, 1'b0);                          // zero-length tick
    push_tick(16'hFFFF, 0, FULL_TURN, 1'b0);           // target of a full turn folds to zero
    drain_all();

    // Crossed limits: the max side must win
    write_reg(REG_MIN_SPEED, CFG_DATA_W'(1000));
    write_reg(REG_MAX_SPEED, CFG_DATA_W'(-1000));
    push_tick(100, 0, 0, 1'b0);
    push_tick(16'hFFFF, 32767, 1000, 1'b0);
    drain_all();

    // Unmapped indexes must leave every register alone
    write_reg(UNUSED_REG_LO, 16'h0000);
    write_reg(UNUSED_REG_HI, 16'hFFFF);
    push_tick(16'hFFFF, -32768, 5000, 1'b0);
    drain_all();

    // Zero rates: speed and heading freeze, position keeps integrating
    write_reg(REG_ACCEL_RATE, 16'h0000);
    write_reg(REG_TURN_RATE, 16'h0000);
    write_reg(REG_MIN_SPEED, 16'h8000);
    write_reg(REG_MAX_SPEED, 16'h7FFF);
    push_tick(16'hFFFF, 32767, 4000, 1'b0);

    // Random phases, each with its own register setting and pacing
    for (int ph = 0; ph < 4; ph++) begin
      drain_all();
      sender_idle_pct = IDLE_PCT[ph];
      recv_stall_pct  = STALL_PCT[ph];
      case (ph)
        0: begin
          write_reg(REG_ACCEL_RATE, CFG_DATA_W'($urandom_range(1023)));
          write_reg(REG_TURN_RATE, CFG_DATA_W'($urandom_range(4095)));
          write_reg(REG_MIN_SPEED, CFG_DATA_W'(-int'($urandom_range(4000))));
          write_reg(REG_MAX_SPEED, CFG_DATA_W'($urandom_range(8000)));
        end
        1: begin
          write_reg(REG_ACCEL_RATE, 16'hFFFF);
          write_reg(REG_TURN_RATE, 16'hFFFF);
          write_reg(REG_MIN_SPEED, 16'h8000);
          write_reg(REG_MAX_SPEED, 16'h7FFF);
        end
        2: begin
          // Any pair of limits, crossed ones included
          write_reg(REG_ACCEL_RATE, CFG_DATA_W'($urandom));
          write_reg(REG_TURN_RATE, CFG_DATA_W'($urandom));
          write_reg(REG_MIN_SPEED, CFG_DATA_W'($urandom));
          write_reg(REG_MAX_SPEED, CFG_DATA_W'($urandom));
        end
        default: begin
          write_reg(REG_ACCEL_RATE, CFG_DATA_W'(ACCEL_DEFAULT));
          write_reg(REG_TURN_RATE, CFG_DATA_W'(TURN_DEFAULT));
          write_reg(REG_MIN_SPEED, CFG_DATA_W'(MIN_DEFAULT));
          write_reg(REG_MAX_SPEED, CFG_DATA_W'(MAX_DEFAULT));
        end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        // Mix full-range tick lengths with short ones so the ramps settle and overshoot
        case ($urandom_range(3))
          0:       dt = $urandom_range(255);
          1:       dt = $urandom_range(4095);
          2:       dt = 65535 - $urandom_range(15);
          default: dt = $urandom_range(65535);
        endcase
        // Aim at a limit now and then so speed pins and the hold branch is taken
        case ($urandom_range(4))
          0:       spd = $urandom_range(1) ? min_cfg : max_cfg;
          1:       spd = int'($urandom_range(6000)) - 3000;
          default: spd = int'($urandom);
        endcase
        head = ($urandom_range(7) == 0) ? $urandom_range(8191, FULL_TURN)
                                        : $urandom_range(FULL_TURN - 1);
        push_tick(dt, spd, head, n == RANDOM_PER_PHASE / 2 || $urandom_range(39) == 0);
      end
    end
    drain_all();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d ticks and checked %0d motion beats across %0d register writes,",
             ticks_accepted, results_seen, reg_writes);
    $display("with directed turn and speed corners plus four handshake pacing mixes.");
    if (error_count == 0 && motion_expected.size() == 0) begin
      $display("ship_kinematics_step_top verification clean");
    end else begin
      $display("%0d mismatches, %0d results never returned", error_count,
               motion_expected.size());
      $display("ship_kinematics_step_top verification failed");
    end
    $finish;
  end

endmodule
